>>> rtl/pmbe_pkg.sv
`default_nettype none
package pmbe_pkg;

  localparam int MAX_ATTRIBUTES = 4;
  localparam int MAX_FREE_BITS  = 6;
  localparam int NUM_BIT_REGS   = 4;
  localparam int ATTR_CAP       = (MAX_ATTRIBUTES < NUM_BIT_REGS) ? MAX_ATTRIBUTES
                                                                  : NUM_BIT_REGS;
  localparam int BITS_CAP       = 16;

  localparam int KEY_HASH_W = 32;
  localparam int POS_W      = 2;
  localparam int HASH_W     = 32;
  localparam int CNT_W      = 3;
  localparam int BITS_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int OWN_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITS_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITS_LAST  = 3'd4;

  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_M5   = 32'd5;
  localparam logic [31:0] MM_ADD  = 32'he6546b64;
  localparam logic [31:0] MM_LEN  = 32'd8;
  localparam logic [31:0] MM_F1   = 32'h85ebca6b;
  localparam logic [31:0] MM_F2   = 32'hc2b2ae35;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_K1,
    OP_K2,
    OP_BLK,
    OP_F1,
    OP_F2,
    OP_F3
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]                     attr_count;
    logic [NUM_BIT_REGS-1:0][BITS_W-1:0]  bits;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/pmbe_in_if.sv
`default_nettype none
interface pmbe_in_if;
  logic                            valid;
  logic                            ready;
  logic [pmbe_pkg::KEY_HASH_W-1:0] key_hash;
  logic [pmbe_pkg::POS_W-1:0]      position;

  modport source (output valid, output key_hash, output position, input ready);
  modport sink   (input valid, input key_hash, input position, output ready);
endinterface
`default_nettype wire

>>> rtl/pmbe_out_if.sv
`default_nettype none
interface pmbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [pmbe_pkg::HASH_W-1:0] bucket_hash;
  logic                        last;
  logic                        error;

  modport source (output valid, output bucket_hash, output last, output error,
                  input ready);
  modport sink   (input valid, input bucket_hash, input last, input error,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/pmbe_cfg_if.sv
`default_nettype none
interface pmbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pmbe_pkg::CFG_IDX_W-1:0]  index;
  logic [pmbe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/partial_match_bucket_enumerator.sv
`default_nettype none
// Partial-match bucket enumerator: per query, one MurmurHash3 x86_32 bucket hash for
// every value of the free key bits, from all ones down to zero, last flagged. All
// hashing runs on one shared 32x32 multiplier stepped by a small sequencer: a query
// is captured and set up, then each bucket hash takes a key build, seven mixing
// steps and a hand-off to the output register; the output side can stall the
// hand-off. A rejected query gives its single error result. in_ready is high only
// between queries.
module partial_match_bucket_enumerator #(
  parameter int MAX_FREE_BITS = pmbe_pkg::MAX_FREE_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pmbe_cfg_if.sink  cfg_ch,
  pmbe_in_if.sink   in_ch,
  pmbe_out_if.source out_ch
);

  localparam int FB_W  = MAX_FREE_BITS;
  localparam int RT_W  = $clog2(MAX_FREE_BITS + 1);
  localparam int SUM_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ERR,
    ST_KEY,
    ST_K1,
    ST_K2,
    ST_B1,
    ST_B2,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  pmbe_pkg::cfg_t                  cfg_q;
  pmbe_pkg::op_t                   op;
  logic [31:0]                     hash;

  logic [pmbe_pkg::KEY_HASH_W-1:0] khash_r;
  logic [pmbe_pkg::POS_W-1:0]      pos_r;
  logic [pmbe_pkg::OWN_W-1:0]      khm_r;
  logic [pmbe_pkg::BITS_W-1:0]     own_r;
  logic [RT_W-1:0]                 right_r;
  logic [FB_W-1:0]                 val_r;
  logic [31:0]                     key_r;

  logic                            out_valid_r;
  logic [pmbe_pkg::HASH_W-1:0]     out_hash_r;
  logic                            out_last_r;
  logic                            out_error_r;

  logic [pmbe_pkg::CNT_W-1:0]      count;
  logic [pmbe_pkg::BITS_W-1:0]     eff [pmbe_pkg::NUM_BIT_REGS];
  logic [SUM_W-1:0]                left_sum;
  logic [SUM_W-1:0]                right_sum;
  logic [SUM_W-1:0]                free_sum;
  logic [pmbe_pkg::BITS_W-1:0]     own;
  logic                            setup_err;
  logic                            out_free;
  logic                            out_load;
  logic [31:0]                     left_val;
  logic [5:0]                      key_sh;
  logic [31:0]                     key_nxt;

  pmbe_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_q (cfg_q)
  );

  pmbe_hash_unit u_hash (
    .clk    (clk),
    .op     (op),
    .key    (key_r),
    .result (hash)
  );

  always_comb begin
    count = (cfg_q.attr_count > pmbe_pkg::CNT_W'(pmbe_pkg::ATTR_CAP))
          ? pmbe_pkg::CNT_W'(pmbe_pkg::ATTR_CAP) : cfg_q.attr_count;
    left_sum  = '0;
    right_sum = '0;
    for (int i = 0; i < pmbe_pkg::NUM_BIT_REGS; i++) begin
      eff[i] = (cfg_q.bits[i] > pmbe_pkg::BITS_W'(pmbe_pkg::BITS_CAP))
             ? pmbe_pkg::BITS_W'(pmbe_pkg::BITS_CAP) : cfg_q.bits[i];
      if (pmbe_pkg::CNT_W'(i) < count) begin
        if (pmbe_pkg::POS_W'(i) < pos_r) begin
          left_sum = left_sum + SUM_W'(eff[i]);
        end else if (pmbe_pkg::POS_W'(i) > pos_r) begin
          right_sum = right_sum + SUM_W'(eff[i]);
        end
      end
    end
    own       = eff[pos_r];
    free_sum  = left_sum + right_sum;
    setup_err = (pmbe_pkg::CNT_W'(pos_r) >= count) ||
                (free_sum > SUM_W'(MAX_FREE_BITS));
  end

  // key = left free bits | own bits | right free bits
  always_comb begin
    left_val = 32'(val_r) >> right_r;
    key_sh   = 6'(own_r) + 6'(right_r);
    key_nxt  = (left_val << key_sh) | (32'(khm_r) << right_r) |
               (32'(val_r) & ~(32'hffffffff << right_r));
  end

  always_comb begin
    case (state_r)
      ST_K1:        op = pmbe_pkg::OP_K1;
      ST_K2:        op = pmbe_pkg::OP_K2;
      ST_B1, ST_B2: op = pmbe_pkg::OP_BLK;
      ST_F1:        op = pmbe_pkg::OP_F1;
      ST_F2:        op = pmbe_pkg::OP_F2;
      ST_F3:        op = pmbe_pkg::OP_F3;
      default:      op = pmbe_pkg::OP_HOLD;
    endcase
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = ((state_r == ST_ERR) || (state_r == ST_EMIT)) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            khash_r <= in_ch.key_hash;
            pos_r   <= in_ch.position;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          own_r   <= own;
          right_r <= RT_W'(right_sum);
          khm_r   <= khash_r[pmbe_pkg::OWN_W-1:0] &
                     ~({pmbe_pkg::OWN_W{1'b1}} << own);
          val_r   <= ~({FB_W{1'b1}} << free_sum);
          state_r <= setup_err ? ST_ERR : ST_KEY;
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_hash_r  <= '0;
            out_last_r  <= 1'b1;
            out_error_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_KEY: begin
          key_r   <= key_nxt;
          state_r <= ST_K1;
        end
        ST_K1: state_r <= ST_K2;
        ST_K2: state_r <= ST_B1;
        ST_B1: state_r <= ST_B2;
        ST_B2: state_r <= ST_F1;
        ST_F1: state_r <= ST_F2;
        ST_F2: state_r <= ST_F3;
        ST_F3: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_hash_r  <= hash;
            out_last_r  <= (val_r == '0);
            out_error_r <= 1'b0;
            if (val_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              val_r   <= val_r - FB_W'(1);
              state_r <= ST_KEY;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.bucket_hash = out_hash_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.error       = out_error_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a request is in progress");

  a_error_sole_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error) |-> (out_ch.last && (out_ch.bucket_hash == '0)))
    else $error("error result not a zero final result");

  a_no_idle_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ch.ready) |=> (state_r == ST_EMIT))
    else $error("bucket hash dropped while output stalled");

endmodule
`default_nettype wire

>>> rtl/pmbe_cfg_regs.sv
`default_nettype none
module pmbe_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  pmbe_cfg_if.sink          cfg,
  output pmbe_pkg::cfg_t    cfg_q
);

  logic [pmbe_pkg::CNT_W-1:0]                                 attr_count_r;
  logic [pmbe_pkg::NUM_BIT_REGS-1:0][pmbe_pkg::BITS_W-1:0]    bits_r;
  logic [pmbe_pkg::CFG_IDX_W-1:0]                             idx_off;

  assign cfg.ready = 1'b1;
  assign idx_off   = cfg.index - pmbe_pkg::CFG_IDX_BITS_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r <= pmbe_pkg::CNT_W'(1);
      bits_r       <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index) inside
        pmbe_pkg::CFG_IDX_COUNT: begin
          attr_count_r <= cfg.data[pmbe_pkg::CNT_W-1:0];
        end
        [pmbe_pkg::CFG_IDX_BITS_FIRST:pmbe_pkg::CFG_IDX_BITS_LAST]: begin
          bits_r[idx_off[1:0]] <= cfg.data[pmbe_pkg::BITS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_q.attr_count = attr_count_r;
  assign cfg_q.bits       = bits_r;

endmodule
`default_nettype wire

>>> rtl/pmbe_hash_unit.sv
`default_nettype none
module pmbe_hash_unit (
  input  wire logic          clk,
  input  wire pmbe_pkg::op_t op,
  input  wire logic [31:0]   key,
  output logic      [31:0]   result
);

  logic [31:0] t_r;
  logic [31:0] t_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] addend;
  logic [31:0] prod;
  logic [31:0] fx;

  // one 32x32 low-half multiplier shared by every multiplying mixing step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    fx     = t_r ^ pmbe_pkg::MM_LEN;
    case (op)
      pmbe_pkg::OP_K1: begin
        mul_a = key;
        mul_b = pmbe_pkg::MM_C1;
      end
      pmbe_pkg::OP_K2: begin
        mul_a = {t_r[16:0], t_r[31:17]};
        mul_b = pmbe_pkg::MM_C2;
      end
      pmbe_pkg::OP_BLK: begin
        mul_a  = {t_r[18:0], t_r[31:19]};
        mul_b  = pmbe_pkg::MM_M5;
        addend = pmbe_pkg::MM_ADD;
      end
      pmbe_pkg::OP_F1: begin
        mul_a = fx ^ {16'b0, fx[31:16]};
        mul_b = pmbe_pkg::MM_F1;
      end
      pmbe_pkg::OP_F2: begin
        mul_a = t_r ^ {13'b0, t_r[31:13]};
        mul_b = pmbe_pkg::MM_F2;
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (op)
      pmbe_pkg::OP_HOLD: t_nxt = t_r;
      pmbe_pkg::OP_F3:   t_nxt = t_r ^ {16'b0, t_r[31:16]};
      default:           t_nxt = prod + addend;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  assign result = t_r;

endmodule
`default_nettype wire
